@@ hdl/ezml_pkg.sv @@
// shared types and constants of the eight-zone midpoint line rasterizer
`default_nettype none

package ezml_pkg;

  localparam int unsigned COORD_BITS_DEFAULT = 12;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_STEP = 1'b1
  } func_e;

  // octant numbering: counterclockwise from the +x axis
  typedef enum logic [2:0] {
    OCT_0 = 3'd0,
    OCT_1 = 3'd1,
    OCT_2 = 3'd2,
    OCT_3 = 3'd3,
    OCT_4 = 3'd4,
    OCT_5 = 3'd5,
    OCT_6 = 3'd6,
    OCT_7 = 3'd7
  } octant_e;

endpackage

`default_nettype wire

@@ hdl/ezml_setup.sv @@
// line setup: octant classification, mirroring into octant 0, decision seeds
`default_nettype none

module ezml_setup import ezml_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic signed [COORD_BITS-1:0] x_start_i,
  input  logic signed [COORD_BITS-1:0] y_start_i,
  input  logic signed [COORD_BITS-1:0] x_end_i,
  input  logic signed [COORD_BITS-1:0] y_end_i,
  output octant_e                      octant_o,
  output logic signed [COORD_BITS:0]   major_o,
  output logic signed [COORD_BITS:0]   minor_o,
  output logic signed [COORD_BITS:0]   limit_o,
  output logic signed [COORD_BITS+2:0] decision_o,
  output logic signed [COORD_BITS+2:0] east_inc_o,
  output logic signed [COORD_BITS+2:0] diag_inc_o
);

  localparam int unsigned W = COORD_BITS + 1;
  localparam int unsigned D = COORD_BITS + 3;

  logic signed [W-1:0] xa, ya, xb, yb;
  logic signed [W-1:0] dx, dy;
  logic        [W-1:0] adx, ady;
  logic                y_major;
  logic signed [W-1:0] a0, b0, a1, b1;
  logic signed [W-1:0] d_major, d_minor;
  logic signed [D-1:0] d_major_ext, d_minor_ext;
  octant_e             oct;

  assign xa = {x_start_i[COORD_BITS-1], x_start_i};
  assign ya = {y_start_i[COORD_BITS-1], y_start_i};
  assign xb = {x_end_i[COORD_BITS-1], x_end_i};
  assign yb = {y_end_i[COORD_BITS-1], y_end_i};

  assign dx = xb - xa;
  assign dy = yb - ya;
  assign adx = dx[W-1] ? W'(-dx) : W'(dx);
  assign ady = dy[W-1] ? W'(-dy) : W'(dy);
  assign y_major = adx < ady;

  // zero differences count as non-negative
  always_comb begin
    if (!y_major) begin
      if (!dx[W-1]) oct = dy[W-1] ? OCT_7 : OCT_0;
      else          oct = dy[W-1] ? OCT_4 : OCT_3;
    end else begin
      if (!dx[W-1]) oct = dy[W-1] ? OCT_6 : OCT_1;
      else          oct = dy[W-1] ? OCT_5 : OCT_2;
    end
  end

  always_comb begin
    unique case (oct)
      OCT_1:   begin a0 = ya;  b0 = xa;  a1 = yb;  b1 = xb;  end
      OCT_2:   begin a0 = ya;  b0 = -xa; a1 = yb;  b1 = -xb; end
      OCT_3:   begin a0 = -xa; b0 = ya;  a1 = -xb; b1 = yb;  end
      OCT_4:   begin a0 = -xa; b0 = -ya; a1 = -xb; b1 = -yb; end
      OCT_5:   begin a0 = -ya; b0 = -xa; a1 = -yb; b1 = -xb; end
      OCT_6:   begin a0 = -ya; b0 = xa;  a1 = -yb; b1 = xb;  end
      OCT_7:   begin a0 = xa;  b0 = -ya; a1 = xb;  b1 = -yb; end
      default: begin a0 = xa;  b0 = ya;  a1 = xb;  b1 = yb;  end
    endcase
  end

  // in octant 0 both differences are non-negative
  assign d_major = a1 - a0;
  assign d_minor = b1 - b0;
  assign d_major_ext = {{2{d_major[W-1]}}, d_major};
  assign d_minor_ext = {{2{d_minor[W-1]}}, d_minor};

  assign octant_o   = oct;
  assign major_o    = a0;
  assign minor_o    = b0;
  assign limit_o    = a1;
  assign east_inc_o = d_minor_ext <<< 1;
  assign decision_o = (d_minor_ext <<< 1) - d_major_ext;
  assign diag_inc_o = (d_minor_ext - d_major_ext) <<< 1;

endmodule

`default_nettype wire

@@ hdl/ezml_walker.sv @@
// line walk state: decision term update and mapping back to the original octant
`default_nettype none

module ezml_walker import ezml_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic                         step_i,
  input  octant_e                      octant_i,
  input  logic signed [COORD_BITS:0]   major_i,
  input  logic signed [COORD_BITS:0]   minor_i,
  input  logic signed [COORD_BITS:0]   limit_i,
  input  logic signed [COORD_BITS+2:0] decision_i,
  input  logic signed [COORD_BITS+2:0] east_inc_i,
  input  logic signed [COORD_BITS+2:0] diag_inc_i,
  output logic                         active_o,
  output logic signed [COORD_BITS-1:0] pixel_x_o,
  output logic signed [COORD_BITS-1:0] pixel_y_o,
  output logic                         last_pixel_o
);

  localparam int unsigned W = COORD_BITS + 1;
  localparam int unsigned D = COORD_BITS + 3;

  logic                active_q, active_d;
  octant_e             octant_q, octant_d;
  logic signed [W-1:0] major_q, major_d;
  logic signed [W-1:0] minor_q, minor_d;
  logic signed [W-1:0] limit_q, limit_d;
  logic signed [D-1:0] decision_q, decision_d;
  logic signed [D-1:0] east_q, east_d;
  logic signed [D-1:0] diag_q, diag_d;
  logic signed [W-1:0] px, py;
  logic                last;

  assign last = major_q >= limit_q;

  always_comb begin
    unique case (octant_q)
      OCT_1:   begin px = minor_q;  py = major_q;  end
      OCT_2:   begin px = -minor_q; py = major_q;  end
      OCT_3:   begin px = -major_q; py = minor_q;  end
      OCT_4:   begin px = -major_q; py = -minor_q; end
      OCT_5:   begin px = -minor_q; py = -major_q; end
      OCT_6:   begin px = minor_q;  py = -major_q; end
      OCT_7:   begin px = major_q;  py = -minor_q; end
      default: begin px = major_q;  py = minor_q;  end
    endcase
  end

  always_comb begin
    active_d   = active_q;
    octant_d   = octant_q;
    major_d    = major_q;
    minor_d    = minor_q;
    limit_d    = limit_q;
    decision_d = decision_q;
    east_d     = east_q;
    diag_d     = diag_q;
    if (load_i) begin
      active_d   = 1'b1;
      octant_d   = octant_i;
      major_d    = major_i;
      minor_d    = minor_i;
      limit_d    = limit_i;
      decision_d = decision_i;
      east_d     = east_inc_i;
      diag_d     = diag_inc_i;
    end else if (step_i && active_q) begin
      // minor axis moves only on a non-negative decision term
      if (decision_q[D-1]) begin
        decision_d = decision_q + east_q;
      end else begin
        decision_d = decision_q + diag_q;
        minor_d    = minor_q + W'(1);
      end
      major_d = major_q + W'(1);
      if (last) active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      octant_q   <= OCT_0;
      major_q    <= '0;
      minor_q    <= '0;
      limit_q    <= '0;
      decision_q <= '0;
      east_q     <= '0;
      diag_q     <= '0;
    end else begin
      active_q   <= active_d;
      octant_q   <= octant_d;
      major_q    <= major_d;
      minor_q    <= minor_d;
      limit_q    <= limit_d;
      decision_q <= decision_d;
      east_q     <= east_d;
      diag_q     <= diag_d;
    end
  end

  assign active_o     = active_q;
  assign pixel_x_o    = px[COORD_BITS-1:0];
  assign pixel_y_o    = py[COORD_BITS-1:0];
  assign last_pixel_o = last;

endmodule

`default_nettype wire

@@ hdl/eight_zone_midpoint_line_raster.sv @@
// Eight-octant midpoint line rasterizer. A load item (func 0) latches two
// endpoints, classifies the line into one of eight octants and seeds the
// walk; it produces no output. Each step item (func 1) on an active line
// produces one pixel in the original coordinate frame, with last_pixel set
// on the final one; a step with no active line produces nothing. One item
// is taken every cycle while the output side keeps up: an accepted item
// sits in an input register; when it moves on, the setup or step logic
// updates the walk state while the pixel is written to the output register,
// from which it is offered. Input is held while the output register is full
// and not being taken.
`default_nettype none

module eight_zone_midpoint_line_raster import ezml_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         func_i,
  input  logic signed [COORD_BITS-1:0] x_start_i,
  input  logic signed [COORD_BITS-1:0] y_start_i,
  input  logic signed [COORD_BITS-1:0] x_end_i,
  input  logic signed [COORD_BITS-1:0] y_end_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0] pixel_x_o,
  output logic signed [COORD_BITS-1:0] pixel_y_o,
  output logic                         last_pixel_o
);

  localparam int unsigned W = COORD_BITS + 1;
  localparam int unsigned D = COORD_BITS + 3;

  logic                         in_valid_q, in_valid_d;
  func_e                        func_q;
  logic signed [COORD_BITS-1:0] x_start_q, y_start_q, x_end_q, y_end_q;
  logic                         out_valid_q, out_valid_d;
  logic signed [COORD_BITS-1:0] pixel_x_q, pixel_y_q;
  logic                         last_q;

  logic                         advance, accept, load, step, emit;
  octant_e                      setup_octant;
  logic signed [W-1:0]          setup_major, setup_minor, setup_limit;
  logic signed [D-1:0]          setup_decision, setup_east, setup_diag;
  logic                         walk_active, walk_last;
  logic signed [COORD_BITS-1:0] walk_x, walk_y;

  // the registered item moves on when the output slot is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;
  assign load       = advance && (func_q == FUNC_LOAD);
  assign step       = advance && (func_q == FUNC_STEP);
  assign emit       = step && walk_active;

  assign in_valid_d = accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q    <= func_e'(func_i);
      x_start_q <= x_start_i;
      y_start_q <= y_start_i;
      x_end_q   <= x_end_i;
      y_end_q   <= y_end_i;
    end
  end

  ezml_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .x_start_i  (x_start_q),
    .y_start_i  (y_start_q),
    .x_end_i    (x_end_q),
    .y_end_i    (y_end_q),
    .octant_o   (setup_octant),
    .major_o    (setup_major),
    .minor_o    (setup_minor),
    .limit_o    (setup_limit),
    .decision_o (setup_decision),
    .east_inc_o (setup_east),
    .diag_inc_o (setup_diag)
  );

  ezml_walker #(
    .COORD_BITS (COORD_BITS)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .step_i       (step),
    .octant_i     (setup_octant),
    .major_i      (setup_major),
    .minor_i      (setup_minor),
    .limit_i      (setup_limit),
    .decision_i   (setup_decision),
    .east_inc_i   (setup_east),
    .diag_inc_i   (setup_diag),
    .active_o     (walk_active),
    .pixel_x_o    (walk_x),
    .pixel_y_o    (walk_y),
    .last_pixel_o (walk_last)
  );

  assign out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pixel_x_q <= walk_x;
      pixel_y_q <= walk_y;
      last_q    <= walk_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = pixel_x_q;
  assign pixel_y_o    = pixel_y_q;
  assign last_pixel_o = last_q;

endmodule

`default_nettype wire
